>>> rtl/plcacc_pkg.sv
// Shared types and constants for the ladder-logic accumulator unit.
// Depends on nothing; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package plcacc_pkg;

    localparam int WORD_W = 16;
    localparam int OPC_W  = 5;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD    = 5'd0,
        OP_LOADNOT = 5'd1,
        OP_AND     = 5'd2,
        OP_ANDNOT  = 5'd3,
        OP_OR      = 5'd4,
        OP_ORNOT   = 5'd5,
        OP_XOR     = 5'd6,
        OP_GT      = 5'd7,
        OP_LT      = 5'd8,
        OP_OUT     = 5'd9,
        OP_OUTNOT  = 5'd10,
        OP_PWM     = 5'd11,
        OP_SET     = 5'd12,
        OP_RESET   = 5'd13,
        OP_LATCH   = 5'd14,
        OP_PUSH    = 5'd15,
        OP_POP     = 5'd16,
        OP_ORBLK   = 5'd17,
        OP_ANDBLK  = 5'd18
    } opcode_t;

    localparam int PWM_SHIFT = 2;

endpackage

`default_nettype wire

>>> rtl/plc_logic_accumulator_unit.sv
// Top level of the ladder-logic accumulator unit: input register, one
// instruction decode/execute step, result register. Uses plcacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Executes one ladder-logic instruction per word against an ACC_WIDTH-bit
// scan accumulator and a STACK_BITS-deep single-bit stack. Throughput is one
// instruction per clock unless the output stalls; an accepted word passes
// the input register, then the result register. The accumulator and stack
// are updated in the same cycle the result register is loaded, so each
// instruction sees the state left by the one before it. The input side keeps
// accepting while a finished result waits, until both registers are full.
module plc_logic_accumulator_unit #(
    parameter int ACC_WIDTH  = 16,
    parameter int STACK_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [plcacc_pkg::OPC_W-1:0]  opcode,
    input  wire logic [plcacc_pkg::WORD_W-1:0] operand,
    input  wire logic [plcacc_pkg::WORD_W-1:0] held_value,
    input  wire logic [plcacc_pkg::WORD_W-1:0] reset_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [plcacc_pkg::WORD_W-1:0]      accumulator,
    output logic                               write_enable,
    output logic [plcacc_pkg::WORD_W-1:0]      write_value
);

    import plcacc_pkg::*;

    localparam int EXT_W = (ACC_WIDTH > WORD_W) ? ACC_WIDTH : WORD_W;
    localparam logic [ACC_WIDTH-1:0] ONE = ACC_WIDTH'(1);

    // input register
    logic                  in_valid_reg;
    logic [OPC_W-1:0]      opcode_reg;
    logic [WORD_W-1:0]     operand_reg;
    logic [WORD_W-1:0]     held_reg;
    logic [WORD_W-1:0]     rst_val_reg;

    // architectural state
    logic [ACC_WIDTH-1:0]  acc_reg, acc_next;
    logic [STACK_BITS-1:0] stack_reg, stack_next;

    // result register
    logic                  out_valid_reg;
    logic [WORD_W-1:0]     acc_out_reg, acc_out_next;
    logic                  we_reg, we_next;
    logic [WORD_W-1:0]     wv_reg, wv_next;

    logic                  advance;
    logic                  in_fire;

    logic [EXT_W-1:0]      x_ext, held_ext, rst_ext, acc_ext, pwm_ext;
    logic [ACC_WIDTH-1:0]  x, held, rstv, a;
    logic [ACC_WIDTH-1:0]  acc_pwm;
    logic                  top_bit;
    logic                  wbit;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign x_ext    = EXT_W'(operand_reg);
    assign held_ext = EXT_W'(held_reg);
    assign rst_ext  = EXT_W'(rst_val_reg);
    assign x        = x_ext[ACC_WIDTH-1:0];
    assign held     = held_ext[ACC_WIDTH-1:0];
    assign rstv     = rst_ext[ACC_WIDTH-1:0];
    assign top_bit  = stack_reg[STACK_BITS-1];
    assign acc_pwm  = acc_reg >> PWM_SHIFT;
    assign pwm_ext  = EXT_W'(acc_pwm);

    always_comb
    begin
        a          = acc_reg;
        stack_next = stack_reg;
        we_next    = 1'b0;
        wbit       = 1'b0;
        wv_next    = '0;
        case (opcode_t'(opcode_reg))
            OP_LOAD:    a = x;
            OP_LOADNOT: a = (x == ONE) ? '0 : ONE;
            OP_AND:     a = acc_reg & x;
            OP_ANDNOT:  a = acc_reg & ~x;
            OP_OR:      a = acc_reg | x;
            OP_ORNOT:
            begin
                if (acc_reg != ONE)
                    a = (x == '0) ? ONE : '0;
            end
            OP_XOR:     a = acc_reg ^ x;
            OP_GT:      a = (acc_reg > x) ? ONE : '0;
            OP_LT:      a = (acc_reg < x) ? ONE : '0;
            OP_OUT:
            begin
                we_next = 1'b1;
                wbit    = (acc_reg == ONE);
                wv_next = WORD_W'(wbit);
            end
            OP_OUTNOT:
            begin
                we_next = 1'b1;
                wbit    = (acc_reg != ONE);
                wv_next = WORD_W'(wbit);
            end
            OP_PWM:
            begin
                we_next = 1'b1;
                wv_next = pwm_ext[WORD_W-1:0];
            end
            OP_SET:
            begin
                a = acc_reg | held;
                if (a == ONE)
                begin
                    we_next = 1'b1;
                    wv_next = WORD_W'(1'b1);
                end
            end
            OP_RESET:   we_next = (acc_reg == ONE);
            OP_LATCH:
            begin
                // self-hold through held_value, break on reset input
                a       = (acc_reg | held) & ~rstv;
                we_next = 1'b1;
                wbit    = (a == ONE);
                wv_next = WORD_W'(wbit);
            end
            OP_PUSH:    stack_next = {acc_reg == ONE, stack_reg[STACK_BITS-1:1]};
            OP_POP:
            begin
                a          = ACC_WIDTH'(top_bit);
                stack_next = {stack_reg[STACK_BITS-2:0], 1'b0};
            end
            OP_ORBLK:
            begin
                a          = acc_reg | ACC_WIDTH'(top_bit);
                stack_next = {stack_reg[STACK_BITS-2:0], 1'b0};
            end
            OP_ANDBLK:
            begin
                a          = acc_reg & ACC_WIDTH'(top_bit);
                stack_next = {stack_reg[STACK_BITS-2:0], 1'b0};
            end
            default:    a = acc_reg;
        endcase
        acc_next     = a;
        acc_ext      = EXT_W'(a);
        acc_out_next = acc_ext[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            stack_reg     <= '0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                stack_reg     <= stack_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg  <= opcode;
            operand_reg <= operand;
            held_reg    <= held_value;
            rst_val_reg <= reset_value;
        end
        if (advance)
        begin
            acc_out_reg <= acc_out_next;
            we_reg      <= we_next;
            wv_reg      <= wv_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accumulator  = acc_out_reg;
    assign write_enable = we_reg;
    assign write_value  = wv_reg;

endmodule

`default_nettype wire

>>> rtl/plcacc_checker.sv
// Port-level checker for the ladder-logic accumulator unit, bound to the
// top level below. Uses plcacc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module plcacc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [plcacc_pkg::WORD_W-1:0] accumulator,
    input wire logic                          write_enable,
    input wire logic [plcacc_pkg::WORD_W-1:0] write_value
);

    import plcacc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accumulator)
            && $stable(write_enable) && $stable(write_value))
        else $error("result word changed while stalled");

    // no write means a zero write value
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> write_value == '0)
        else $error("write value nonzero without write enable");

    // input side only backs up behind a stalled result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input not ready without an output stall");

    // an accepted word with an empty output reaches the output through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("accepted word did not reach the output");

endmodule

bind plc_logic_accumulator_unit plcacc_checker u_plcacc_checker (.*);

`default_nettype wire
